### hw/rtl/b2l_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2l_pkg: shared constants and helpers for the BGR to L*u*v* converter
// Holds the color matrix, white-point and offset constants, the pipeline
// control struct and the elaboration-time lightness table generator.
// ----------------------------------------------------------------------------
package b2l_pkg;

  // Default parameter values.
  localparam int LUT_ENTRIES_DEF   = 1025;
  localparam int FRACTION_BITS_DEF = 16;

  // Matrix rows in millionths, columns ordered blue, green, red.
  localparam longint unsigned ROW_X0 = 178325;
  localparam longint unsigned ROW_X1 = 341550;
  localparam longint unsigned ROW_X2 = 430574;
  localparam longint unsigned ROW_Y0 = 71330;
  localparam longint unsigned ROW_Y1 = 706655;
  localparam longint unsigned ROW_Y2 = 222015;
  localparam longint unsigned ROW_Z0 = 939180;
  localparam longint unsigned ROW_Z1 = 129553;
  localparam longint unsigned ROW_Z2 = 20183;

  // Full-scale Y in millionths times 255, used to form the table index.
  localparam longint unsigned Y_FULL_SCALE = 255000000;

  // White-point terms 13*un and 13*vn in millionths, offsets over 270.
  localparam longint unsigned WHITE_U  = 2571829;
  localparam longint unsigned WHITE_V  = 6088303;
  localparam longint unsigned OFFSET_U = 88;
  localparam longint unsigned OFFSET_V = 134;

  // Width of the channel products and of the denominator.
  localparam int XYZ_W = 29;
  localparam int DEN_W = 33;

  // Control that travels with each beat through the pipeline.
  typedef struct packed {
    logic valid;
    logic dz;
  } b2l_ctl_t;

  // Shift-subtract division, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= b) begin
        r    = r - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // One lightness table entry: linear below the knee, cube root above it.
  function automatic logic [63:0] lut_entry(input logic [63:0] i, input logic [63:0] n,
                                            input int f);
    logic [63:0] one;
    logic [63:0] den;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] c;
    logic [63:0] t;
    logic [63:0] num;
    one = 64'd1 << f;
    if (i * 64'd24389 <= 64'd216 * n) begin
      den = 64'd7290 * n;
      return udiv64(i * 64'd24389 * one + (den >> 1), den);
    end
    r = i;
    q = '0;
    c = '0;
    for (int k = 0; k < 63; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= n) begin
        r    = r - n;
        q[0] = 1'b1;
      end
    end
    for (int k = 20; k >= 0; k--) begin
      t = c | (64'd1 << k);
      if (t * t * t <= q) begin
        c = t;
      end
    end
    num = (64'd116 * c - (64'd16 << 21)) * one;
    den = 64'd270 << 21;
    return udiv64(num + (den >> 1), den);
  endfunction

endpackage

### hw/rtl/b2l_ratio_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2l_ratio_div: pipelined restoring dividers
// Produces the u and v ratios over the shared denominator, one quotient bit
// per stage, and carries the corrected table index alongside them.
// ----------------------------------------------------------------------------
module b2l_ratio_div
  import b2l_pkg::*;
#(
  parameter int QW = FRACTION_BITS_DEF + 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  b2l_ctl_t                 ctl_in,
  input  logic [DEN_W-1:0]         den,
  input  logic [DEN_W+QW-1:0]      num_u,
  input  logic [DEN_W+QW-1:0]      num_v,
  input  logic [DEN_W+QW-1:0]      num_y,
  input  logic [QW-1:0]            est_y,
  output b2l_ctl_t                 ctl_out,
  output logic [QW-1:0]            quo_u,
  output logic [QW-1:0]            quo_v,
  output logic [QW-1:0]            quo_y
);

  localparam int NW = DEN_W + QW;
  localparam logic [NW-1:0] Y_DIV = NW'(Y_FULL_SCALE);

  b2l_ctl_t          ctl [QW+1];
  logic [DEN_W-1:0]  dv  [QW+1];
  logic [NW-1:0]     ru  [QW+1];
  logic [NW-1:0]     rv  [QW+1];
  logic [QW-1:0]     qu  [QW+1];
  logic [QW-1:0]     qv  [QW+1];

  logic [QW-1:0]     ey1;
  logic [NW-1:0]     ym1;
  logic [NW-1:0]     pc1;
  logic [QW-1:0]     iy  [QW-1];

  assign ctl[0] = ctl_in;
  assign dv[0]  = den;
  assign ru[0]  = num_u;
  assign rv[0]  = num_v;
  assign qu[0]  = '0;
  assign qv[0]  = '0;

  // Each stage decides one quotient bit, highest bit first.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] sh_d;
    logic          ge_u;
    logic          ge_v;

    assign sh_d = NW'(dv[s]) << (QW - 1 - s);
    assign ge_u = ru[s] >= sh_d;
    assign ge_v = rv[s] >= sh_d;

    // Valid and the zero-denominator flag ride with the data.
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1] <= '0;
      end else begin
        ctl[s+1] <= ctl[s];
      end
    end

    // Partial remainders and quotients; payload needs no reset.
    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      ru[s+1] <= ge_u ? ru[s] - sh_d : ru[s];
      rv[s+1] <= ge_v ? rv[s] - sh_d : rv[s];
      qu[s+1] <= {qu[s][QW-2:0], ge_u};
      qv[s+1] <= {qv[s][QW-2:0], ge_v};
    end
  end

  // Table index: the estimate is at most one low, so one product and one
  // compare settle it; it is then delayed to line up with the ratios.
  always_ff @(posedge clk) begin
    ey1   <= est_y;
    ym1   <= num_y;
    pc1   <= (NW'(est_y) + NW'(1)) * Y_DIV;
    iy[0] <= (pc1 <= ym1) ? ey1 + QW'(1) : ey1;
    for (int j = 1; j < QW - 1; j++) begin
      iy[j] <= iy[j-1];
    end
  end

  assign ctl_out = ctl[QW];
  assign quo_u   = qu[QW];
  assign quo_v   = qv[QW];
  assign quo_y   = iy[QW-2];

endmodule

### hw/rtl/bgr_to_luv_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_luv_pixel: 8-bit BGR pixel to fixed-point L*u*v*
// Matrix to XYZ, lightness table lookup and chroma ratios, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock cycle and busy always reads low. Each
// result appears on lightness, u_chroma and v_chroma for one cycle with done
// high, after stage 1, stage 2, the divider and stages A, B and C; the divider
// resolves one quotient bit per stage over FRACTION_BITS + 7 stages. Results
// come out in order and must be captured in the cycle they appear, as the
// output cannot be held.
module bgr_to_luv_pixel
  import b2l_pkg::*;
#(
  parameter int LUT_ENTRIES   = LUT_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         blue,
  input  logic [7:0]         green,
  input  logic [7:0]         red,
  output logic               done,
  output logic [15:0]        lightness,
  output logic signed [17:0] u_chroma,
  output logic signed [17:0] v_chroma
);

  localparam int F   = FRACTION_BITS;
  localparam int QW  = F + 7;
  localparam int NW  = DEN_W + QW;
  localparam int IW  = $clog2(LUT_ENTRIES);
  localparam int LQW = F;
  localparam int KW  = QW + 2;
  localparam int PW  = LQW + 1 + KW;

  localparam longint unsigned ONE_Q = 64'd1 << F;
  localparam longint unsigned WU_Q  = (WHITE_U * ONE_Q + 500000) / 1000000;
  localparam longint unsigned WV_Q  = (WHITE_V * ONE_Q + 500000) / 1000000;
  localparam longint unsigned OFU_Q = (OFFSET_U * ONE_Q + 135) / 270;
  localparam longint unsigned OFV_Q = (OFFSET_V * ONE_Q + 135) / 270;

  // Reciprocal of the full-scale Y times LUT_ENTRIES - 1, scaled by 2^IDX_SH;
  // with Y below 2^28 the estimate it gives is never high and at most one low.
  localparam int IDX_SH = 30;
  localparam logic [15:0] IDX_RCP =
    16'(((64'd1 << IDX_SH) * 64'(LUT_ENTRIES - 1)) / Y_FULL_SCALE);

  typedef logic [LQW-1:0] lut_t [LUT_ENTRIES];

  function automatic lut_t build_lut();
    lut_t t;
    for (int i = 0; i < LUT_ENTRIES; i++) begin
      t[i] = LQW'(lut_entry(64'(i), 64'(LUT_ENTRIES), F));
    end
    return t;
  endfunction

  localparam lut_t LUT = build_lut();

  // Saturate a signed sum to the 18-bit chroma range.
  function automatic logic [17:0] sat18(input logic signed [PW:0] v);
    if (v > $signed((PW+1)'(131071))) begin
      return 18'h1FFFF;
    end else if (v < -$signed((PW+1)'(131072))) begin
      return 18'h20000;
    end
    return v[17:0];
  endfunction

  assign busy = 1'b0;

  // Stage 1: matrix products.
  logic              v1;
  logic [XYZ_W-1:0]  x1;
  logic [XYZ_W-1:0]  y1;
  logic [XYZ_W-1:0]  z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= XYZ_W'(ROW_X0 * blue + ROW_X1 * green + ROW_X2 * red);
    y1 <= XYZ_W'(ROW_Y0 * blue + ROW_Y1 * green + ROW_Y2 * red);
    z1 <= XYZ_W'(ROW_Z0 * blue + ROW_Z1 * green + ROW_Z2 * red);
  end

  // Stage 2: denominator, rounded numerators and the index estimate.
  logic [DEN_W-1:0]   d_next;
  logic [XYZ_W+15:0]  yr_next;
  b2l_ctl_t           ctl2;
  logic [DEN_W-1:0]   d2;
  logic [NW-1:0]      nu2;
  logic [NW-1:0]      nv2;
  logic [NW-1:0]      ny2;
  logic [QW-1:0]      ey2;

  assign d_next  = DEN_W'(x1) + DEN_W'(y1) * DEN_W'(15) + DEN_W'(z1) * DEN_W'(3);
  assign yr_next = (XYZ_W+16)'(y1) * (XYZ_W+16)'(IDX_RCP);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else begin
      ctl2.valid <= v1;
      ctl2.dz    <= d_next == '0;
    end
  end

  always_ff @(posedge clk) begin
    d2  <= d_next;
    nu2 <= ((NW'(x1) * NW'(52)) << F) + NW'(d_next >> 1);
    nv2 <= ((NW'(y1) * NW'(117)) << F) + NW'(d_next >> 1);
    ny2 <= NW'(y1) * NW'(LUT_ENTRIES - 1);
    ey2 <= QW'(yr_next >> IDX_SH);
  end

  // Divider stages.
  b2l_ctl_t      ctl3;
  logic [QW-1:0] qu3;
  logic [QW-1:0] qv3;
  logic [QW-1:0] qy3;

  b2l_ratio_div #(
    .QW(QW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl2),
    .den    (d2),
    .num_u  (nu2),
    .num_v  (nv2),
    .num_y  (ny2),
    .est_y  (ey2),
    .ctl_out(ctl3),
    .quo_u  (qu3),
    .quo_v  (qv3),
    .quo_y  (qy3)
  );

  // Stage A: table read and white-point subtraction.
  logic [IW-1:0]        idx;
  logic [QW-1:0]        ru;
  logic [QW-1:0]        rv;
  logic                 va;
  logic [LQW-1:0]       lqa;
  logic signed [KW-1:0] kua;
  logic signed [KW-1:0] kva;

  assign idx = (qy3 > QW'(LUT_ENTRIES - 1)) ? IW'(LUT_ENTRIES - 1) : qy3[IW-1:0];
  assign ru  = ctl3.dz ? '0 : qu3;
  assign rv  = ctl3.dz ? '0 : qv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= ctl3.valid;
    end
  end

  always_ff @(posedge clk) begin
    lqa <= LUT[idx];
    kua <= $signed({2'b00, ru}) - $signed(KW'(WU_Q));
    kva <= $signed({2'b00, rv}) - $signed(KW'(WV_Q));
  end

  // Stage B: lightness times ratio term.
  logic                 vb;
  logic [LQW-1:0]       lqb;
  logic signed [PW-1:0] pub;
  logic signed [PW-1:0] pvb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    lqb <= lqa;
    pub <= $signed(PW'(lqa)) * $signed(PW'(kua));
    pvb <= $signed(PW'(lqa)) * $signed(PW'(kva));
  end

  // Stage C: rounding, offset and saturation into the output registers.
  logic signed [PW:0] su;
  logic signed [PW:0] sv;
  logic [31:0]        lqw;

  assign su  = ((PW+1)'(pub) + $signed((PW+1)'(ONE_Q >> 1))) >>> F;
  assign sv  = ((PW+1)'(pvb) + $signed((PW+1)'(ONE_Q >> 1))) >>> F;
  assign lqw = 32'(lqb);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb;
    end
  end

  always_ff @(posedge clk) begin
    lightness <= (lqw > 32'd65535) ? 16'hFFFF : lqw[15:0];
    u_chroma  <= sat18(su + $signed((PW+1)'(OFU_Q)));
    v_chroma  <= sat18(sv + $signed((PW+1)'(OFV_Q)));
  end

endmodule
